[rtl/core/clearance_distance_map_stamper_unit_macros.svh]
// assertion macros for the clearance distance map stamper
// used by the top level; no other dependencies
`ifndef CLEARANCE_DISTANCE_MAP_STAMPER_UNIT_MACROS_SVH
`define CLEARANCE_DISTANCE_MAP_STAMPER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CDMS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CDMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDMS_ASSERT(lbl, clk, rst, prop, msg)
`define CDMS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/cdms_pkg.sv]
// shared types, codes and constants of the distance map stamper
// no dependencies
`default_nettype none
package cdms_pkg;

  localparam int CELL_W  = 14;
  localparam int DIM_W   = 9;
  localparam int COORD_W = 12;
  localparam int LIFT_W  = 12;
  localparam int IDX_IN_W = 16;

  localparam logic [CELL_W-1:0] EMPTY_VALUE = 14'd9999;

  // configuration register indexes
  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ACT_CLEAR = 3'd0,
    ACT_BALL  = 3'd1,
    ACT_RECT  = 3'd2,
    ACT_OVAL  = 3'd3,
    ACT_READ  = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    T_BUILD, T_CLEAR, T_IDLE, T_LOAD, T_BASE, T_STAMP, T_DRAIN, T_READ, T_FETCH, T_DONE
  } top_state_t;

  typedef enum logic [2:0] {
    B_SQX, B_SQY, B_SCALE, B_START, B_ROOT, B_DONE
  } bld_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bld_status_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [7:0]                hw;
    logic [7:0]                hh;
    logic [LIFT_W-1:0]         lift;
  } job_t;

  // elaboration-time integer square root
  function automatic int isqrt_const(input int n);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r++;
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/cdms_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module cdms_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/core/cdms_sqrt.sv]
// iterative integer square root, two radicand bits per cycle
// no package dependencies
`default_nettype none
module cdms_sqrt #(
  parameter int IN_W = 28
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [IN_W-1:0]     radicand,
  output logic      [IN_W/2-1:0]   root,
  output logic                     done
);
  localparam int OUT_W = IN_W / 2;
  localparam int REM_W = OUT_W + 2;
  localparam int CW    = $clog2(OUT_W + 1);

  logic [IN_W-1:0]  rad_sh;
  logic [REM_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             fits;

  always_comb begin
    rem_sh = {rem, rad_sh[IN_W-1 -: 2]};
    trial  = (REM_W + 2)'({root, 2'b01});
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(OUT_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh <= radicand;
      rem    <= '0;
      root   <= '0;
    end else if (busy) begin
      rad_sh <= rad_sh << 2;
      if (fits) begin
        rem  <= REM_W'(rem_sh - trial);
        root <= {root[OUT_W-2:0], 1'b1};
      end else begin
        rem  <= REM_W'(rem_sh);
        root <= {root[OUT_W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

[rtl/core/cdms_tbuild.sv]
// builds the quarter table of capped scaled distances after reset
// depends on cdms_pkg and cdms_sqrt
`default_nettype none
module cdms_tbuild import cdms_pkg::*; #(
  parameter int REACH      = 32,
  parameter int DIST_SCALE = 5
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  output logic                                     twe,
  output logic [2*$clog2(REACH+1)-1:0]             twaddr,
  output logic [CELL_W-1:0]                        twdata,
  output bld_status_t                              status
);
  localparam int IDX_W  = $clog2(REACH + 1);
  localparam int SQ_W   = 2 * IDX_W + 1;
  localparam int MB_W   = (IDX_W > 9) ? IDX_W : 9;
  localparam int RAD_W0 = SQ_W + 9;
  localparam int RAD_W  = RAD_W0 + (RAD_W0 % 2);
  localparam int RT_W   = RAD_W / 2;
  localparam int CAP    = DIST_SCALE * isqrt_const(2 * REACH * REACH) + 1;

  bld_state_t             state, state_next;
  logic [IDX_W-1:0]       dx, dy;
  logic [SQ_W-1:0]        acc;
  logic [RAD_W-1:0]       rad;
  logic [SQ_W-1:0]        mul_a;
  logic [MB_W-1:0]        mul_b;
  logic [SQ_W+MB_W-1:0]   prod;
  logic                   sq_start, sq_done;
  logic [RT_W-1:0]        sq_root;
  logic                   last_dx, last_dy;

  cdms_sqrt #(.IN_W(RAD_W)) u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(rad), .root(sq_root), .done(sq_done)
  );

  assign last_dx = dx == IDX_W'(REACH);
  assign last_dy = dy == IDX_W'(REACH);
  assign prod    = mul_a * mul_b;

  always_comb begin
    state_next = state;
    unique case (state)
      B_SQX:   state_next = B_SQY;
      B_SQY:   state_next = B_SCALE;
      B_SCALE: state_next = B_START;
      B_START: state_next = B_ROOT;
      B_ROOT:  if (sq_done) state_next = (last_dx && last_dy) ? B_DONE : B_SQX;
      B_DONE:  state_next = B_DONE;
      default: state_next = B_DONE;
    endcase
  end

  always_comb begin
    mul_a       = SQ_W'(dx);
    mul_b       = MB_W'(dx);
    sq_start    = 1'b0;
    twe         = 1'b0;
    twaddr      = {dy, dx};
    twdata      = (int'(sq_root) > CAP) ? CELL_W'(CAP) : CELL_W'(sq_root);
    status.busy = state != B_DONE;
    status.done = state == B_DONE;
    unique case (state)
      B_SQX: begin
        mul_a = SQ_W'(dx);
        mul_b = MB_W'(dx);
      end
      B_SQY: begin
        mul_a = SQ_W'(dy);
        mul_b = MB_W'(dy);
      end
      B_SCALE: begin
        mul_a = acc;
        mul_b = MB_W'(DIST_SCALE * DIST_SCALE);
      end
      B_START: sq_start = 1'b1;
      B_ROOT:  twe = sq_done;
      B_DONE:  ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_SQX;
      dx    <= '0;
      dy    <= '0;
    end else begin
      state <= state_next;
      if (state == B_ROOT && sq_done) begin
        if (last_dx) begin
          dx <= '0;
          dy <= dy + IDX_W'(1);
        end else begin
          dx <= dx + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_SQX:   acc <= SQ_W'(prod);
      B_SQY:   acc <= acc + SQ_W'(prod);
      B_SCALE: rad <= RAD_W'(prod);
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[rtl/core/clearance_distance_map_stamper_unit.sv]
// clearance distance map stamper, top level: sequencer, clear sweep, stamp walker
// depends on cdms_pkg, cdms_ram, cdms_tbuild and the assertion macro header
//
//  channel  signals                         direction  payload
//  in       in_valid / in_stall             to block   action, center_x/y, size_a/b, cell_index
//  out      out_valid / out_stall           from block cell_value, was_read
//  cfg      cfg_valid / cfg_ready           to block   cfg_index, cfg_data
//
// one grid read-modify-write per cycle through the single grid ram port pair:
// ball walks a (2*REACH+1)^2 window, rect a (2*max(w/2,REACH)+1) by
// (2*max(h/2,REACH)+1) window with skipped rows, oval up to three such passes.
// clear sweeps all MAX_WIDTH*MAX_HEIGHT cells, one a cycle.
// after reset the distance table is built, (REACH+1)^2 entries through the
// square root unit of the table builder, then a clear sweep; in_stall
// stays high until then. a result waits in the output register while out_stall is high.
`default_nettype none
`include "clearance_distance_map_stamper_unit_macros.svh"
module clearance_distance_map_stamper_unit import cdms_pkg::*; #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int REACH        = 32,
  parameter int DIST_SCALE   = 5,
  parameter int BORDER_RINGS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          action,
  input  wire logic [7:0]          center_x,
  input  wire logic [7:0]          center_y,
  input  wire logic [7:0]          size_a,
  input  wire logic [7:0]          size_b,
  input  wire logic [IDX_IN_W-1:0] cell_index,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [CELL_W-1:0]        cell_value,
  output logic                     was_read,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [DIM_W-1:0]    cfg_data
);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = (AW > DIM_W) ? AW : DIM_W;
  localparam int IDX_W = $clog2(REACH + 1);
  localparam int TAW   = 2 * IDX_W;
  localparam int W_RST = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;
  localparam int H_RST = (256 > MAX_HEIGHT) ? MAX_HEIGHT : 256;
  localparam logic signed [COORD_W-1:0] C_ONE   = 1;
  localparam logic signed [COORD_W-1:0] C_ZERO  = 0;
  localparam logic signed [COORD_W-1:0] REACH_S = COORD_W'(REACH);

  top_state_t state, state_next;

  logic [DIM_W-1:0] map_width, map_height, snap_w, snap_h;
  logic             accept;

  // item registers
  logic [2:0]          itm_action;
  logic [IDX_IN_W-1:0] itm_idx;
  logic                has_item;
  logic [CELL_W-1:0]   res_value;
  logic                res_read;
  logic                read_ok;

  // stamp jobs
  job_t       jobs [3];
  job_t       new_jobs [3];
  logic [1:0] new_cnt;
  logic [1:0] job_cnt, job_idx;
  job_t       cur;
  logic       last_job;

  // window and walker
  logic signed [COORD_W-1:0] sx, sy, lo_x, hi_x, lo_y, hi_y, wlast, hlast;
  logic signed [COORD_W-1:0] xa_c, xb_c, ya_c, yb_c;
  logic                      win_empty;
  logic signed [COORD_W-1:0] win_xa, win_xb, win_yb, win_ya;
  logic signed [COORD_W-1:0] px, py, hws, hhs, ex, ey, ax, ay;
  logic                      row_ok, cell_ok, row_end, walk_end;
  logic [AW-1:0]             row_base;
  logic [2*DIM_W-1:0]        base_prod;
  logic [AW+2*DIM_W-1:0]     base_wide;
  logic [AW+COORD_W-1:0]     px_wide;
  logic                      s1_valid;
  logic [AW-1:0]             s1_pos;
  logic [CELL_W-1:0]         s1_cand;

  // clear sweep
  logic [AW-1:0]    clr_addr, clr_y;
  logic [DIM_W-1:0] clr_x;
  logic [EW-1:0]    e_l, e_r, e_t, e_b, e_min;
  logic             clr_in_map, clr_ring, clr_last;
  logic [CELL_W-1:0] clr_wdata;

  // memories
  logic              grid_we;
  logic [AW-1:0]     grid_waddr, grid_raddr;
  logic [CELL_W-1:0] grid_wdata, grid_rdata;
  logic [TAW-1:0]    tbl_raddr, tbl_waddr;
  logic [CELL_W-1:0] tbl_rdata, tbl_wdata;
  logic              tbl_we;
  bld_status_t       bld_st;
  logic              out_load;
  logic [AW+IDX_IN_W-1:0] idx_wide;

  cdms_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_grid (
    .clk(clk), .we(grid_we), .waddr(grid_waddr), .wdata(grid_wdata),
    .raddr(grid_raddr), .rdata(grid_rdata)
  );

  cdms_ram #(.WIDTH(CELL_W), .DEPTH(2 ** TAW)) u_table (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  cdms_tbuild #(.REACH(REACH), .DIST_SCALE(DIST_SCALE)) u_tbuild (
    .clk(clk), .rst(rst), .twe(tbl_we), .twaddr(tbl_waddr), .twdata(tbl_wdata),
    .status(bld_st)
  );

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  // job list for the incoming item
  always_comb begin
    logic signed [COORD_W-1:0] cxs, cys, ctr;
    logic [7:0] d, dh, r;
    cxs = $signed(COORD_W'(center_x));
    cys = $signed(COORD_W'(center_y));
    d   = '0;
    dh  = '0;
    r   = '0;
    ctr = '0;
    for (int i = 0; i < 3; i++) begin
      new_jobs[i] = '{cx: cxs, cy: cys, hw: 8'd0, hh: 8'd0, lift: '0};
    end
    new_cnt = 2'd1;
    if (action == ACT_BALL) begin
      new_jobs[0].lift = LIFT_W'(int'(size_a) * DIST_SCALE);
    end else if (action == ACT_RECT) begin
      new_jobs[0].hw = size_a >> 1;
      new_jobs[0].hh = size_b >> 1;
    end else begin
      new_cnt = 2'd3;
      if (size_a > size_b) begin
        d  = size_a - size_b;
        dh = d >> 1;
        r  = size_b >> 1;
        new_jobs[0].hw = dh;
        new_jobs[0].hh = size_b >> 1;
        ctr = cxs - $signed(COORD_W'(dh));
        new_jobs[1].cx   = (ctr < C_ZERO) ? C_ZERO : ctr;
        new_jobs[2].cx   = cxs + $signed(COORD_W'(dh));
      end else begin
        d  = size_b - size_a;
        dh = d >> 1;
        r  = size_a >> 1;
        new_jobs[0].hw = size_a >> 1;
        new_jobs[0].hh = dh;
        ctr = cys - $signed(COORD_W'(dh));
        new_jobs[1].cy   = (ctr < C_ZERO) ? C_ZERO : ctr;
        new_jobs[2].cy   = cys + $signed(COORD_W'(dh));
      end
      new_jobs[1].lift = LIFT_W'(int'(r) * DIST_SCALE);
      new_jobs[2].lift = LIFT_W'(int'(r) * DIST_SCALE);
    end
  end

  // window of the current job, clipped to the map
  always_comb begin
    cur      = jobs[job_idx];
    last_job = job_idx == job_cnt - 2'd1;
    hws      = $signed(COORD_W'(cur.hw));
    hhs      = $signed(COORD_W'(cur.hh));
    sx       = (hws > REACH_S) ? hws : REACH_S;
    sy       = (hhs > REACH_S) ? hhs : REACH_S;
    lo_x     = cur.cx - sx;
    hi_x     = cur.cx + sx;
    lo_y     = cur.cy - sy;
    hi_y     = cur.cy + sy;
    wlast    = $signed(COORD_W'(map_width)) - C_ONE;
    hlast    = $signed(COORD_W'(map_height)) - C_ONE;
    xa_c     = (lo_x < C_ZERO) ? C_ZERO : lo_x;
    xb_c     = (hi_x > wlast) ? wlast : hi_x;
    ya_c     = (lo_y < C_ZERO) ? C_ZERO : lo_y;
    yb_c     = (hi_y > hlast) ? hlast : hi_y;
    win_empty = (xa_c > xb_c) || (ya_c > yb_c);
  end

  // walker: edge distances of the current cell
  always_comb begin
    if (py > cur.cy + hhs) ey = py - cur.cy - hhs;
    else if (py < cur.cy - hhs) ey = cur.cy - hhs - py;
    else ey = C_ZERO;
    if (px > cur.cx + hws) ex = px - cur.cx - hws;
    else if (px < cur.cx - hws) ex = cur.cx - hws - px;
    else ex = C_ZERO;
    ay       = (py > cur.cy) ? py - cur.cy : cur.cy - py;
    ax       = (px > cur.cx) ? px - cur.cx : cur.cx - px;
    row_ok   = (ey == C_ZERO) || (ay <= REACH_S);
    cell_ok  = row_ok && ((ex == C_ZERO) || (ax <= REACH_S));
    row_end  = !row_ok || (px == win_xb);
    walk_end = row_end && (py == win_yb);
    px_wide  = {AW'(0), px};
    tbl_raddr = {ey[IDX_W-1:0], ex[IDX_W-1:0]};
    base_prod = DIM_W'(win_ya) * map_width;
    base_wide = {AW'(0), base_prod};
    s1_cand   = (tbl_rdata > CELL_W'(cur.lift)) ? tbl_rdata - CELL_W'(cur.lift) : '0;
    idx_wide  = {AW'(0), itm_idx};
  end

  // clear sweep value
  always_comb begin
    e_l        = EW'(clr_x);
    e_r        = EW'(snap_w - DIM_W'(1) - clr_x);
    e_t        = EW'(clr_y);
    e_b        = EW'(snap_h) - EW'(1) - EW'(clr_y);
    clr_in_map = EW'(clr_y) < EW'(snap_h);
    e_min      = e_l;
    if (e_t < e_min) e_min = e_t;
    if (e_r < e_min) e_min = e_r;
    if (e_b < e_min) e_min = e_b;
    clr_ring   = clr_in_map && (int'(e_min) < BORDER_RINGS);
    clr_wdata  = clr_ring ? CELL_W'((int'(e_min) + 1) * DIST_SCALE) : EMPTY_VALUE;
    clr_last   = clr_addr == AW'(DEPTH - 1);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      T_BUILD: if (bld_st.done) state_next = T_CLEAR;
      T_CLEAR: if (clr_last) state_next = has_item ? T_DONE : T_IDLE;
      T_IDLE: begin
        if (accept) begin
          unique case (action) inside
            ACT_CLEAR:                   state_next = T_CLEAR;
            ACT_BALL, ACT_RECT, ACT_OVAL: state_next = T_LOAD;
            ACT_READ:                    state_next = T_READ;
            default:                     state_next = T_DONE;
          endcase
        end
      end
      T_LOAD:  if (win_empty) state_next = last_job ? T_DONE : T_LOAD;
               else state_next = T_BASE;
      T_BASE:  state_next = T_STAMP;
      T_STAMP: if (walk_end) state_next = T_DRAIN;
      T_DRAIN: state_next = last_job ? T_DONE : T_LOAD;
      T_READ:  state_next = T_FETCH;
      T_FETCH: state_next = T_DONE;
      T_DONE:  if (!out_valid || !out_stall) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall   = state != T_IDLE;
    out_load   = (state == T_DONE) && (!out_valid || !out_stall);
    grid_we    = s1_valid && (grid_rdata > s1_cand);
    grid_waddr = s1_pos;
    grid_wdata = s1_cand;
    grid_raddr = row_base + px_wide[AW-1:0];
    unique case (state)
      T_CLEAR: begin
        grid_we    = 1'b1;
        grid_waddr = clr_addr;
        grid_wdata = clr_wdata;
      end
      T_READ:  grid_raddr = idx_wide[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_BUILD;
      map_width  <= DIM_W'(W_RST);
      map_height <= DIM_W'(H_RST);
      snap_w     <= DIM_W'(W_RST);
      snap_h     <= DIM_W'(H_RST);
      clr_addr   <= '0;
      clr_x      <= '0;
      clr_y      <= '0;
      out_valid  <= 1'b0;
      has_item   <= 1'b0;
      s1_valid   <= 1'b0;
      job_idx    <= '0;
      job_cnt    <= '0;
    end else begin
      state    <= state_next;
      s1_valid <= (state == T_STAMP) && cell_ok;
      out_valid <= out_load || (out_valid && out_stall);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAP_WIDTH) begin
          if (cfg_data == '0) map_width <= DIM_W'(1);
          else if (int'(cfg_data) > MAX_WIDTH) map_width <= DIM_W'(MAX_WIDTH);
          else map_width <= cfg_data;
        end else begin
          if (cfg_data == '0) map_height <= DIM_W'(1);
          else if (int'(cfg_data) > MAX_HEIGHT) map_height <= DIM_W'(MAX_HEIGHT);
          else map_height <= cfg_data;
        end
      end
      if (accept) begin
        has_item <= 1'b1;
        job_idx  <= '0;
        job_cnt  <= new_cnt;
        clr_addr <= '0;
        clr_x    <= '0;
        clr_y    <= '0;
        snap_w   <= map_width;
        snap_h   <= map_height;
      end
      if (out_load) has_item <= 1'b0;
      if (state == T_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_x == snap_w - DIM_W'(1)) begin
          clr_x <= '0;
          clr_y <= clr_y + AW'(1);
        end else begin
          clr_x <= clr_x + DIM_W'(1);
        end
      end
      if ((state == T_LOAD && win_empty) || state == T_DRAIN) begin
        job_idx <= job_idx + 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      itm_action <= action;
      itm_idx    <= cell_index;
      res_value  <= '0;
      res_read   <= action == ACT_READ;
      for (int i = 0; i < 3; i++) jobs[i] <= new_jobs[i];
    end
    if (out_load) begin
      cell_value <= res_value;
      was_read   <= res_read;
    end
    unique case (state)
      T_LOAD: begin
        win_xa <= xa_c;
        win_xb <= xb_c;
        win_ya <= ya_c;
        win_yb <= yb_c;
        px     <= xa_c;
        py     <= ya_c;
      end
      T_BASE: row_base <= base_wide[AW-1:0];
      T_STAMP: begin
        s1_pos <= grid_raddr;
        if (row_end) begin
          px       <= win_xa;
          py       <= py + C_ONE;
          row_base <= row_base + AW'(map_width);
        end else begin
          px <= px + C_ONE;
        end
      end
      T_READ:  read_ok <= (2*DIM_W)'(itm_idx) < map_width * map_height;
      T_FETCH: if (itm_action == ACT_READ && read_ok) res_value <= grid_rdata;
      default: ;
    endcase
  end

  `CDMS_ASSERT(a_grid_we_state, clk, rst, grid_we |-> (state == T_CLEAR || state == T_STAMP || state == T_DRAIN), "grid write outside clear or stamp")
  `CDMS_ASSERT(a_tbl_we_build, clk, rst, tbl_we |-> (bld_st.busy && state == T_BUILD), "table write after build")
  `CDMS_ASSERT(a_busy_after_accept, clk, rst, accept |=> in_stall, "item taken while busy")
  `CDMS_ASSERT_ALWAYS(a_zero_unless_read, clk, (out_valid && !was_read) |-> (cell_value == '0), "nonzero value without read")

endmodule
`default_nettype wire

[dv/clearance_distance_map_stamper_unit_tb.sv]
// self-checking testbench for the clearance distance map stamper: random and directed items
// with a behavioral copy of the distance grid; depends on cdms_pkg and the top level
`timescale 1ns / 1ps
module clearance_distance_map_stamper_unit_tb;
  import cdms_pkg::*;

  localparam int MAP_MAX_W   = 256;
  localparam int MAP_MAX_H   = 256;
  localparam int WIN_REACH   = 32;
  localparam int UNIT_SCALE  = 5;
  localparam int EDGE_RINGS  = 16;
  localparam int IDLE_LIMIT  = 300000;

  typedef struct {
    logic [2:0]  act;
    logic [7:0]  cx;
    logic [7:0]  cy;
    logic [7:0]  sa;
    logic [7:0]  sb;
    logic [15:0] idx;
  } stamp_cmd_t;

  typedef struct {
    logic [CELL_W-1:0] value;
    logic              rd;
  } cell_reply_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready, cfg_index;
  logic [2:0] action;
  logic [7:0] center_x, center_y, size_a, size_b;
  logic [IDX_IN_W-1:0] cell_index;
  logic [CELL_W-1:0] cell_value;
  logic was_read;
  logic [DIM_W-1:0] cfg_data;

  clearance_distance_map_stamper_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .center_x(center_x), .center_y(center_y),
    .size_a(size_a), .size_b(size_b), .cell_index(cell_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .cell_value(cell_value), .was_read(was_read),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // behavioral copy of the block state
  logic [CELL_W-1:0] dist_grid [0:MAP_MAX_W*MAP_MAX_H-1];
  int dist_lut [0:WIN_REACH][0:WIN_REACH];
  int cur_w, cur_h;

  stamp_cmd_t  pending_cmds[$];
  cell_reply_t expected_replies[$];
  int mismatches;
  int idle_cycles;
  int in_gap, out_hold;
  bit quiet;

  function automatic longint floor_sqrt(longint n);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r++;
    return r;
  endfunction

  function automatic void build_lut();
    int cap;
    cap = UNIT_SCALE * int'(floor_sqrt(2 * WIN_REACH * WIN_REACH)) + 1;
    for (int dy = 0; dy <= WIN_REACH; dy++)
      for (int dx = 0; dx <= WIN_REACH; dx++) begin
        int v;
        v = int'(floor_sqrt(longint'(dx * dx + dy * dy) * UNIT_SCALE * UNIT_SCALE));
        dist_lut[dy][dx] = (v > cap) ? cap : v;
      end
  endfunction

  function automatic void map_clear();
    for (int i = 0; i < MAP_MAX_W * MAP_MAX_H; i++) dist_grid[i] = EMPTY_VALUE;
    for (int y = 0; y < cur_h; y++)
      for (int x = 0; x < cur_w; x++) begin
        int e;
        e = x;
        if (y < e) e = y;
        if (cur_w - 1 - x < e) e = cur_w - 1 - x;
        if (cur_h - 1 - y < e) e = cur_h - 1 - y;
        if (e < EDGE_RINGS) dist_grid[y * cur_w + x] = CELL_W'((e + 1) * UNIT_SCALE);
      end
  endfunction

  function automatic int edge_gap(int p, int c, int half);
    if (p < c - half) return c - half - p;
    if (p > c + half) return p - c - half;
    return 0;
  endfunction

  function automatic void map_stamp(int cx, int cy, int hw, int hh, int lift);
    int xa, xb, ya, yb;
    xa = cx - ((hw > WIN_REACH) ? hw : WIN_REACH);
    xb = cx + ((hw > WIN_REACH) ? hw : WIN_REACH);
    ya = cy - ((hh > WIN_REACH) ? hh : WIN_REACH);
    yb = cy + ((hh > WIN_REACH) ? hh : WIN_REACH);
    if (xa < 0) xa = 0;
    if (ya < 0) ya = 0;
    if (xb > cur_w - 1) xb = cur_w - 1;
    if (yb > cur_h - 1) yb = cur_h - 1;
    for (int y = ya; y <= yb; y++) begin
      int ey, ay;
      ey = edge_gap(y, cy, hh);
      ay = (y > cy) ? y - cy : cy - y;
      if (ey > 0 && ay > WIN_REACH) continue;
      for (int x = xa; x <= xb; x++) begin
        int ex, ax, v, pos;
        ex = edge_gap(x, cx, hw);
        ax = (x > cx) ? x - cx : cx - x;
        if (ex > 0 && ax > WIN_REACH) continue;
        v = dist_lut[ey][ex] - lift;
        if (v < 0) v = 0;
        pos = y * cur_w + x;
        if (dist_grid[pos] > v) dist_grid[pos] = CELL_W'(v);
      end
    end
  endfunction

  function automatic void map_ball(int cx, int cy, int radius);
    // oval end centres may fall below zero and are clamped
    map_stamp((cx < 0) ? 0 : cx, (cy < 0) ? 0 : cy, 0, 0, radius * UNIT_SCALE);
  endfunction

  function automatic void map_oval(int cx, int cy, int w, int h);
    if (w > h) begin
      map_stamp(cx, cy, (w - h) / 2, h / 2, 0);
      map_ball(cx - (w - h) / 2, cy, h / 2);
      map_ball(cx + (w - h) / 2, cy, h / 2);
    end else begin
      map_stamp(cx, cy, w / 2, (h - w) / 2, 0);
      map_ball(cx, cy - (h - w) / 2, w / 2);
      map_ball(cx, cy + (h - w) / 2, w / 2);
    end
  endfunction

  function automatic cell_reply_t apply_cmd(stamp_cmd_t c);
    cell_reply_t r;
    r.value = '0;
    r.rd = 1'b0;
    case (c.act)
      ACT_CLEAR: map_clear();
      ACT_BALL:  map_ball(c.cx, c.cy, c.sa);
      ACT_RECT:  map_stamp(c.cx, c.cy, c.sa / 2, c.sb / 2, 0);
      ACT_OVAL:  map_oval(c.cx, c.cy, c.sa, c.sb);
      ACT_READ: begin
        if (int'(c.idx) < cur_w * cur_h) r.value = dist_grid[c.idx];
        r.rd = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic stamp_cmd_t mk_cmd(logic [2:0] a, int cx, int cy, int sa, int sb, int idx);
    stamp_cmd_t c;
    c.act = a; c.cx = 8'(cx); c.cy = 8'(cy); c.sa = 8'(sa); c.sb = 8'(sb); c.idx = 16'(idx);
    return c;
  endfunction

  function automatic stamp_cmd_t rand_cmd();
    stamp_cmd_t c;
    int r;
    c = mk_cmd(ACT_READ, $urandom_range(0, 99) < 70 ? $urandom_range(0, cur_w - 1) : $urandom,
               $urandom_range(0, 99) < 70 ? $urandom_range(0, cur_h - 1) : $urandom,
               $urandom_range(0, 40), $urandom_range(0, 40),
               $urandom_range(0, 99) < 85 ? $urandom_range(0, cur_w * cur_h - 1) : $urandom);
    r = $urandom_range(0, 99);
    if (r < 45) c.act = ACT_READ;
    else if (r < 70) begin
      c.act = ACT_BALL;
      c.sa = 8'($urandom);   // window cost does not depend on radius
      c.sb = 8'($urandom);
    end else if (r < 85) begin
      c.act = ACT_RECT;
      if ($urandom_range(0, 49) == 0) c.sa = 8'($urandom);
    end else if (r < 96) c.act = ACT_OVAL;
    else if (r < 97) c.act = ACT_CLEAR;
    else c.act = 3'($urandom_range(5, 7));
    return c;
  endfunction

  task automatic write_reg(logic ri, int v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= DIM_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    v = v & 9'h1FF;
    if (ri == REG_MAP_WIDTH) cur_w = (v < 1) ? 1 : (v > MAP_MAX_W) ? MAP_MAX_W : v;
    else cur_h = (v < 1) ? 1 : (v > MAP_MAX_H) ? MAP_MAX_H : v;
  endtask

  // checked between edges so no item can sit on the input unaccepted
  task automatic drain();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_replies.size() != 0);
  endtask

  task automatic run_phase(int w, int h, int n_rand, bit with_clear);
    write_reg(REG_MAP_WIDTH, w);
    write_reg(REG_MAP_HEIGHT, h);
    if (with_clear) pending_cmds.push_back(mk_cmd(ACT_CLEAR, 0, 0, 0, 0, 0));
    // the first cell, the far corner and one index past the map
    pending_cmds.push_back(mk_cmd(ACT_READ, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_READ, 0, 0, 0, 0, cur_w * cur_h - 1));
    pending_cmds.push_back(mk_cmd(ACT_READ, 0, 0, 0, 0, cur_w * cur_h));
    repeat (n_rand) pending_cmds.push_back(rand_cmd());
    drain();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_replies.push_back(apply_cmd(mk_cmd(action, center_x, center_y,
                                                     size_a, size_b, cell_index)));
      if (in_valid && in_stall) begin
        // hold the stalled item
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        stamp_cmd_t c;
        c = pending_cmds.pop_front();
        in_valid <= 1'b1;
        action <= c.act; center_x <= c.cx; center_y <= c.cy;
        size_a <= c.sa; size_b <= c.sb; cell_index <= c.idx;
        if (!quiet && $urandom_range(0, 3) == 0) in_gap <= $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_hold <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: value %0d read %0b",
                                         cell_value, was_read);
        end else begin
          cell_reply_t e;
          e = expected_replies.pop_front();
          if (e.value !== cell_value || e.rd !== was_read) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value %0d read %0b, got value %0d read %0b",
                       e.value, e.rd, cell_value, was_read);
          end
        end
      end
      if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 5) == 0) out_hold <= $urandom_range(1, 9);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0; out_stall = 1'b0; cfg_valid = 1'b0; cfg_index = REG_MAP_WIDTH;
    cfg_data = '0; action = ACT_CLEAR; center_x = '0; center_y = '0;
    size_a = '0; size_b = '0; cell_index = '0;
    mismatches = 0; idle_cycles = 0; quiet = 1'b0;
    cur_w = MAP_MAX_W; cur_h = MAP_MAX_H;
    build_lut();
    map_clear();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed items on the full map
    pending_cmds.push_back(mk_cmd(ACT_READ, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_READ, 0, 0, 0, 0, 16 * 256 + 16));
    pending_cmds.push_back(mk_cmd(ACT_READ, 0, 0, 0, 0, 15 * 256 + 100));
    pending_cmds.push_back(mk_cmd(ACT_BALL, 0, 0, 0, 255, 0));
    pending_cmds.push_back(mk_cmd(ACT_BALL, 255, 255, 255, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_READ, 0, 0, 0, 0, 65535));
    pending_cmds.push_back(mk_cmd(ACT_BALL, 128, 128, 3, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_READ, 0, 0, 0, 0, 128 * 256 + 130));
    pending_cmds.push_back(mk_cmd(ACT_RECT, 60, 70, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_RECT, 200, 20, 1, 200, 0));
    pending_cmds.push_back(mk_cmd(ACT_RECT, 128, 128, 255, 255, 0));
    pending_cmds.push_back(mk_cmd(ACT_READ, 0, 0, 0, 0, 200 * 256 + 40));
    pending_cmds.push_back(mk_cmd(ACT_OVAL, 0, 0, 200, 10, 0));
    pending_cmds.push_back(mk_cmd(ACT_OVAL, 90, 3, 6, 180, 0));
    pending_cmds.push_back(mk_cmd(ACT_OVAL, 40, 40, 9, 9, 0));
    pending_cmds.push_back(mk_cmd(ACT_READ, 0, 0, 0, 0, 3 * 256 + 2));
    pending_cmds.push_back(mk_cmd(3'd5, 255, 255, 255, 255, 65535));
    pending_cmds.push_back(mk_cmd(3'd6, 1, 2, 3, 4, 5));
    pending_cmds.push_back(mk_cmd(3'd7, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_CLEAR, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_READ, 0, 0, 0, 0, 128 * 256 + 130));
    drain();

    // register settings, extremes first
    run_phase(0, 0, 6, 1'b1);
    run_phase(511, 511, 18, 1'b0);
    run_phase(37, 50, 18, 1'b1);
    run_phase(256, 1, 10, 1'b0);
    run_phase(1, 256, 10, 1'b1);
    run_phase($urandom_range(1, 300), $urandom_range(1, 300), 14, 1'b0);
    quiet = 1'b1;
    run_phase(256, 256, 20, 1'b1);

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
